// ===== rtl/core/ezrm_pkg.sv =====
// ----------------------------------------------------------------------------
// ezrm_pkg
// Shared types and constants for the z-x-z Euler angle rotation matrix block.
// ----------------------------------------------------------------------------
package ezrm_pkg;

  localparam int CORDIC_FRAC = 30;
  localparam int TURN_BITS   = 32;
  localparam int XW          = 33;
  localparam int ZW          = 33;
  localparam int NUM_LANES   = 3;
  localparam int LANE_PHI    = 0;
  localparam int LANE_THETA  = 1;
  localparam int LANE_PSI    = 2;
  localparam int FIELD_W     = 16;
  localparam int ELEM_W      = 16;
  localparam int NUM_ELEM    = 9;
  localparam int MAX_STAGES  = 32;

  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // arctan(2^-i) in 2^32-per-turn units
  localparam logic [31:0] ATAN_TURN [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef struct packed {
    logic [1:0]             quad;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } lane_t;

endpackage

// ===== rtl/core/ezrm_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ezrm_cordic_cell
// One rotation-mode CORDIC micro-rotation for the three angle lanes.
// ----------------------------------------------------------------------------
module ezrm_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ezrm_pkg::lane_t in_lane [ezrm_pkg::NUM_LANES],
  output logic            out_valid,
  input  logic            out_ready,
  output ezrm_pkg::lane_t out_lane [ezrm_pkg::NUM_LANES]
);

  localparam int XW = ezrm_pkg::XW;
  localparam int ZW = ezrm_pkg::ZW;
  localparam int NL = ezrm_pkg::NUM_LANES;
  localparam logic signed [ZW-1:0] ANGLE_STEP = ZW'(ezrm_pkg::ATAN_TURN[SHIFT]);

  logic signed [XW-1:0] dx [NL];
  logic signed [XW-1:0] dy [NL];
  ezrm_pkg::lane_t      lane_next [NL];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      dx[k] = $signed(in_lane[k].y) >>> SHIFT;
      dy[k] = $signed(in_lane[k].x) >>> SHIFT;
      lane_next[k].quad = in_lane[k].quad;
      if (!in_lane[k].z[ZW-1]) begin
        lane_next[k].x = $signed(in_lane[k].x) - dx[k];
        lane_next[k].y = $signed(in_lane[k].y) + dy[k];
        lane_next[k].z = $signed(in_lane[k].z) - ANGLE_STEP;
      end else begin
        lane_next[k].x = $signed(in_lane[k].x) + dx[k];
        lane_next[k].y = $signed(in_lane[k].y) - dy[k];
        lane_next[k].z = $signed(in_lane[k].z) + ANGLE_STEP;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_lane <= lane_next;
    end
  end

endmodule

// ===== rtl/core/ezrm_trig_cell.sv =====
// ----------------------------------------------------------------------------
// ezrm_trig_cell
// Quadrant unfold, rounding and clamping of the CORDIC outputs to sin/cos.
// ----------------------------------------------------------------------------
module ezrm_trig_cell #(
  parameter int FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ezrm_pkg::lane_t            in_lane [ezrm_pkg::NUM_LANES],
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [FRAC_BITS+1:0] sn [ezrm_pkg::NUM_LANES],
  output logic signed [FRAC_BITS+1:0] cs [ezrm_pkg::NUM_LANES]
);

  localparam int XW = ezrm_pkg::XW;
  localparam int NL = ezrm_pkg::NUM_LANES;
  localparam int SW = FRAC_BITS + 2;
  localparam int RS = ezrm_pkg::CORDIC_FRAC - FRAC_BITS;
  localparam logic signed [XW:0] HALF = (RS > 0) ? (XW+1)'(2**(RS-1)) : '0;
  localparam logic signed [XW:0] ONE  = (XW+1)'(2**FRAC_BITS);

  logic signed [XW-1:0] c_raw [NL];
  logic signed [XW-1:0] s_raw [NL];
  logic signed [SW-1:0] sn_next [NL];
  logic signed [SW-1:0] cs_next [NL];

  function automatic logic signed [SW-1:0] to_frac(input logic signed [XW-1:0] v);
    logic signed [XW:0] t;
    t = ($signed({v[XW-1], v}) + HALF) >>> RS;
    if (t > ONE) begin
      t = ONE;
    end else if (t < -ONE) begin
      t = -ONE;
    end
    return SW'(t);
  endfunction

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      unique case (in_lane[k].quad)
        ezrm_pkg::QUAD_0: begin
          c_raw[k] = in_lane[k].x;
          s_raw[k] = in_lane[k].y;
        end
        ezrm_pkg::QUAD_1: begin
          c_raw[k] = -$signed(in_lane[k].y);
          s_raw[k] = in_lane[k].x;
        end
        ezrm_pkg::QUAD_2: begin
          c_raw[k] = -$signed(in_lane[k].x);
          s_raw[k] = -$signed(in_lane[k].y);
        end
        ezrm_pkg::QUAD_3: begin
          c_raw[k] = in_lane[k].y;
          s_raw[k] = -$signed(in_lane[k].x);
        end
      endcase
      sn_next[k] = to_frac(s_raw[k]);
      cs_next[k] = to_frac(c_raw[k]);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      sn <= sn_next;
      cs <= cs_next;
    end
  end

endmodule

// ===== rtl/core/ezrm_matrix.sv =====
// ----------------------------------------------------------------------------
// ezrm_matrix
// Three-stage product and sum pipeline forming the nine matrix elements.
// ----------------------------------------------------------------------------
module ezrm_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [FRAC_BITS+1:0] sn [ezrm_pkg::NUM_LANES],
  input  logic signed [FRAC_BITS+1:0] cs [ezrm_pkg::NUM_LANES],
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ezrm_pkg::NUM_ELEM*ezrm_pkg::ELEM_W-1:0] out_data
);

  localparam int SW  = FRAC_BITS + 2;
  localparam int SW1 = SW + 1;
  localparam int PW  = 2 * SW;
  localparam int EW  = ezrm_pkg::ELEM_W;
  localparam int NL  = ezrm_pkg::NUM_LANES;
  localparam int PHI = ezrm_pkg::LANE_PHI;
  localparam int THE = ezrm_pkg::LANE_THETA;
  localparam int PSI = ezrm_pkg::LANE_PSI;
  localparam int M_XX = 0;
  localparam int M_XY = 1;
  localparam int M_XZ = 2;
  localparam int M_YX = 3;
  localparam int M_YY = 4;
  localparam int M_YZ = 5;
  localparam int M_ZX = 6;
  localparam int M_ZY = 7;
  localparam int M_ZZ = 8;
  localparam logic signed [PW-1:0]  HALF = PW'(2**(FRAC_BITS-1));
  localparam logic signed [SW1-1:0] ONE  = SW1'(2**FRAC_BITS);

  function automatic logic signed [SW-1:0] mul(input logic signed [SW-1:0] a,
                                               input logic signed [SW-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    p = (p + HALF) >>> FRAC_BITS;
    return SW'(p);
  endfunction

  function automatic logic [EW-1:0] clamp_out(input logic signed [SW1-1:0] v);
    logic signed [SW1-1:0] t;
    t = v;
    if (t > ONE) begin
      t = ONE;
    end else if (t < -ONE) begin
      t = -ONE;
    end
    return EW'(t);
  endfunction

  logic                 valid_a, valid_b;
  logic                 ready_a, ready_b, ready_c;
  logic signed [SW-1:0] tsp, tcp;
  logic signed [SW-1:0] a_sn [NL];
  logic signed [SW-1:0] a_cs [NL];
  logic signed [SW-1:0] q_tsp_s, q_tcp_s, q_tsp_c, q_tcp_c;
  logic signed [SW-1:0] p_cc, p_cs, p_sst, p_sc, p_cst, p_sts, p_stc, p_ss, b_ct;
  logic [ezrm_pkg::NUM_ELEM*EW-1:0] data_next;

  assign ready_c  = !out_valid || out_ready;
  assign ready_b  = !valid_b || ready_c;
  assign ready_a  = !valid_a || ready_b;
  assign in_ready = ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a <= in_valid;
      end
      if (ready_b) begin
        valid_b <= valid_a;
      end
      if (ready_c) begin
        out_valid <= valid_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      tsp  <= mul(cs[THE], sn[PHI]);
      tcp  <= mul(cs[THE], cs[PHI]);
      a_sn <= sn;
      a_cs <= cs;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      q_tsp_s <= mul(tsp, a_sn[PSI]);
      q_tcp_s <= mul(tcp, a_sn[PSI]);
      q_tsp_c <= mul(tsp, a_cs[PSI]);
      q_tcp_c <= mul(tcp, a_cs[PSI]);
      p_cc    <= mul(a_cs[PSI], a_cs[PHI]);
      p_cs    <= mul(a_cs[PSI], a_sn[PHI]);
      p_sst   <= mul(a_sn[PSI], a_sn[THE]);
      p_sc    <= mul(a_sn[PSI], a_cs[PHI]);
      p_cst   <= mul(a_cs[PSI], a_sn[THE]);
      p_sts   <= mul(a_sn[THE], a_sn[PHI]);
      p_stc   <= mul(a_sn[THE], a_cs[PHI]);
      p_ss    <= mul(a_sn[PSI], a_sn[PHI]);
      b_ct    <= a_cs[THE];
    end
  end

  always_comb begin
    data_next = '0;
    data_next[EW*M_XX +: EW] = clamp_out(SW1'(p_cc) - SW1'(q_tsp_s));
    data_next[EW*M_XY +: EW] = clamp_out(SW1'(p_cs) + SW1'(q_tcp_s));
    data_next[EW*M_XZ +: EW] = clamp_out(SW1'(p_sst));
    data_next[EW*M_YX +: EW] = clamp_out(-SW1'(p_sc) - SW1'(q_tsp_c));
    data_next[EW*M_YY +: EW] = clamp_out(-SW1'(p_ss) + SW1'(q_tcp_c));
    data_next[EW*M_YZ +: EW] = clamp_out(SW1'(p_cst));
    data_next[EW*M_ZX +: EW] = clamp_out(SW1'(p_sts));
    data_next[EW*M_ZY +: EW] = clamp_out(-SW1'(p_stc));
    data_next[EW*M_ZZ +: EW] = clamp_out(SW1'(b_ct));
  end

  always_ff @(posedge clk) begin
    if (ready_c) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/core/euler_zxz_rotation_matrix_top.sv =====
// ----------------------------------------------------------------------------
// euler_zxz_rotation_matrix_top
// Rotation matrix from z-x-z Euler angles given as binary angles.
// Pipeline: one cell per CORDIC micro-rotation, one sin/cos cell, three
// product and sum stages. Throughput: one item per cycle while the output
// side is not stalled.
// Reset clears all stage valid flags; the payload registers are not reset.
// ----------------------------------------------------------------------------
module euler_zxz_rotation_matrix_top #(
  parameter int ANGLE_BITS    = 16,
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // angle_phi, angle_theta, angle_psi
  input  logic [ezrm_pkg::NUM_LANES*ezrm_pkg::FIELD_W-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // m_xx, m_xy, m_xz, m_yx, m_yy, m_yz, m_zx, m_zy, m_zz
  output logic [ezrm_pkg::NUM_ELEM*ezrm_pkg::ELEM_W-1:0] m_axis_tdata
);

  localparam int NL     = ezrm_pkg::NUM_LANES;
  localparam int FW     = ezrm_pkg::FIELD_W;
  localparam int ZW     = ezrm_pkg::ZW;
  localparam int ZSCALE = ezrm_pkg::TURN_BITS - ANGLE_BITS;
  localparam int SW     = FRAC_BITS + 2;

  logic [ANGLE_BITS-1:0] angle [NL];
  ezrm_pkg::lane_t       fold [NL];
  ezrm_pkg::lane_t       chain [CORDIC_STAGES][NL];
  logic [CORDIC_STAGES-1:0] cell_valid, cell_ready;
  logic                  trig_valid, trig_ready, mat_ready;
  logic signed [SW-1:0]  sn [NL];
  logic signed [SW-1:0]  cs [NL];

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      angle[k]     = ANGLE_BITS'(s_axis_tdata[FW*k +: FW]);
      fold[k].quad = angle[k][ANGLE_BITS-1 -: 2];
      fold[k].x    = ezrm_pkg::CORDIC_GAIN;
      fold[k].y    = '0;
      fold[k].z    = ZW'(angle[k][ANGLE_BITS-3:0]) << ZSCALE;
    end
  end

  assign s_axis_tready = cell_ready[0];

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
    logic down_ready;
    if (s == CORDIC_STAGES - 1) begin : g_last
      assign down_ready = trig_ready;
    end else begin : g_mid
      assign down_ready = cell_ready[s+1];
    end
    if (s == 0) begin : g_first
      ezrm_cordic_cell #(.SHIFT(s)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (s_axis_tvalid),
        .in_ready  (cell_ready[s]),
        .in_lane   (fold),
        .out_valid (cell_valid[s]),
        .out_ready (down_ready),
        .out_lane  (chain[s])
      );
    end else begin : g_next
      ezrm_cordic_cell #(.SHIFT(s)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (cell_valid[s-1]),
        .in_ready  (cell_ready[s]),
        .in_lane   (chain[s-1]),
        .out_valid (cell_valid[s]),
        .out_ready (down_ready),
        .out_lane  (chain[s])
      );
    end
  end

  ezrm_trig_cell #(.FRAC_BITS(FRAC_BITS)) u_trig (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cell_valid[CORDIC_STAGES-1]),
    .in_ready  (trig_ready),
    .in_lane   (chain[CORDIC_STAGES-1]),
    .out_valid (trig_valid),
    .out_ready (mat_ready),
    .sn        (sn),
    .cs        (cs)
  );

  ezrm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_valid),
    .in_ready  (mat_ready),
    .sn        (sn),
    .cs        (cs),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== rtl/core/ezrm_checker.sv =====
// ----------------------------------------------------------------------------
// ezrm_checker
// Port-level checks for the rotation matrix block, bound to the top level.
// ----------------------------------------------------------------------------
module ezrm_checker #(
  parameter int FRAC_BITS = 14
) (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [ezrm_pkg::NUM_ELEM*ezrm_pkg::ELEM_W-1:0] m_axis_tdata
);

  localparam int EW  = ezrm_pkg::ELEM_W;
  localparam int LIM = 2**FRAC_BITS;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output item valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  for (genvar k = 0; k < ezrm_pkg::NUM_ELEM; k++) begin : g_range
    logic signed [EW-1:0] elem;
    assign elem = m_axis_tdata[EW*k +: EW];
    a_elem_range: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && (FRAC_BITS <= EW - 2) |-> (elem <= LIM) && (elem >= -LIM))
      else $error("matrix element outside unit range");
  end

endmodule

bind euler_zxz_rotation_matrix_top ezrm_checker #(.FRAC_BITS(FRAC_BITS)) u_ezrm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
